@@ src/itt_pkg.sv @@
// shared types and constants for the interrupt transfer tracker
`timescale 1ns / 1ps

package itt_pkg;

  // default size of the buffer pool
  localparam int BufferCountDefault = 16;

  // action codes carried in s_tuser
  localparam logic [1:0] ACT_ARM     = 2'd0;
  localparam logic [1:0] ACT_DELIVER = 2'd1;
  localparam logic [1:0] ACT_TAKE    = 2'd2;

  // code given to entries retired without their own event
  localparam logic [7:0] CODE_SUCCESS = 8'd1;

  // outstanding queue entry
  typedef struct packed {
    logic [15:0] gen;
    logic [16:0] len;
    logic [3:0]  buf_id;
    logic [63:0] addr;
  } pend_word_t;

  // completion queue entry
  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] gen;
    logic [16:0] res;
    logic [16:0] req;
    logic [3:0]  buf_id;
    logic [63:0] addr;
  } comp_word_t;

  // free-buffer scan handshake
  typedef struct packed {
    logic start;
  } scan_ctl_t;

endpackage

@@ src/itt_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module itt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/itt_free_scan.sv @@
// walks the free map one buffer a cycle to find the lowest free buffer
`timescale 1ns / 1ps

module itt_free_scan #(
  parameter int BUFFER_COUNT = itt_pkg::BufferCountDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  itt_pkg::scan_ctl_t           ctl,
  input  logic [BUFFER_COUNT-1:0]      free_map,
  output logic                         done,
  output logic [$clog2(BUFFER_COUNT+1)-1:0] first
);

  localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int CW = $clog2(BUFFER_COUNT + 1);

  logic          busy;
  logic [CW-1:0] pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pos  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (busy) begin
        if (free_map[pos[IW-1:0]]) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          first <= pos;
        end else if (pos == CW'(BUFFER_COUNT - 1)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          first <= CW'(BUFFER_COUNT);
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

@@ src/interrupt_in_transfer_tracker_unit.sv @@
// top level of the interrupt transfer tracker: sequencer, queues and counters
`timescale 1ns / 1ps

// Tracks a pool of BUFFER_COUNT receive buffers (free, in flight, completed).
// Each input word carries an action in s_tuser: arm a free buffer with an
// address and length (its 16-bit generation is bumped and it joins the
// outstanding queue), deliver a completion event (the outstanding queue is
// searched for the address; older entries retire as skipped successes, the
// match retires with the event code and a residue clamped to its length; a
// miss counts as lost), or take the oldest completion (freeing its buffer and
// counting a generation fault if the buffer was re-armed). Both queues are
// circular rams with head pointers; the generation table is a ram whose
// entries read as zero until first written. One word produces exactly one
// result word. The block takes one word at a time: s_tready is high only
// while the sequencer is idle. A delivery searches the outstanding entries
// and then retires entries from the head, and every word ends with the
// one-bit-a-cycle scan for the lowest free buffer of the pool.
// Every access to the queues goes through a single registered ram read port
// each, so every step of the search and retire loops has a read state
// followed by a check or write state. The result sits in an output register,
// so the next word may be taken while it waits.
module interrupt_in_transfer_tracker_unit #(
  parameter int BUFFER_COUNT = itt_pkg::BufferCountDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // buf_index[3:0], transfer_address[67:4], request_length[84:68],
  // completion_code[92:85], residue_length[116:93], zero fill
  input  logic [119:0] s_tdata,
  // action[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted[0], done_address[64:1], done_buffer[68:65], done_requested[85:69],
  // done_residue[102:86], done_actual[119:103], done_generation[135:120],
  // done_code[143:136], first_free[148:144], lost_count[180:149],
  // skipped_count[212:181], generation_fault_count[244:213], zero fill
  output logic [247:0] m_tdata
);

  localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int CW = $clog2(BUFFER_COUNT + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ARM_RD   = 4'd1;
  localparam logic [3:0] S_ARM_WR   = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_RET_RD   = 4'd5;
  localparam logic [3:0] S_RET_WR   = 4'd6;
  localparam logic [3:0] S_TAKE_RD  = 4'd7;
  localparam logic [3:0] S_TAKE_GEN = 4'd8;
  localparam logic [3:0] S_TAKE_WR  = 4'd9;
  localparam logic [3:0] S_FREE_GO  = 4'd10;
  localparam logic [3:0] S_FREE_WT  = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  logic [3:0] state;

  // latched input word
  logic [3:0]  in_buf;
  logic [63:0] in_addr;
  logic [16:0] in_len;
  logic [7:0]  in_code;
  logic [23:0] in_res;

  // queue pointers
  logic [IW-1:0] phead, chead, scan_ptr;
  logic [CW-1:0] pcount, ccount, scan_k, ret_left;

  // per-buffer status: free, completed, in flight when neither
  logic [BUFFER_COUNT-1:0] freev, compv, genv;

  // result being built
  logic        ok;
  logic [63:0] t_addr;
  logic [3:0]  t_buf;
  logic [16:0] t_req, t_res;
  logic [15:0] t_gen;
  logic [7:0]  t_code;
  logic [CW-1:0] ff;
  logic [31:0] lost_cnt, skip_cnt, gfault_cnt;

  // ram ports
  logic                gen_we;
  logic [IW-1:0]       gen_waddr, gen_raddr;
  logic [15:0]         gen_wdata, gen_rdata;
  logic                pend_we;
  logic [IW-1:0]       pend_waddr, pend_raddr;
  itt_pkg::pend_word_t pend_wdata, pend_rdata;
  logic                comp_we;
  logic [IW-1:0]       comp_waddr, comp_raddr;
  itt_pkg::comp_word_t comp_wdata, comp_rdata;

  // free scan
  itt_pkg::scan_ctl_t scan_ctl;
  logic               scan_done;
  logic [CW-1:0]      scan_first;

  itt_ram #(.WIDTH(16), .DEPTH(BUFFER_COUNT)) u_gen_ram (
    .clk(clk), .we(gen_we), .waddr(gen_waddr), .wdata(gen_wdata),
    .raddr(gen_raddr), .rdata(gen_rdata)
  );

  itt_ram #(.WIDTH($bits(itt_pkg::pend_word_t)), .DEPTH(BUFFER_COUNT)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

  itt_ram #(.WIDTH($bits(itt_pkg::comp_word_t)), .DEPTH(BUFFER_COUNT)) u_comp_ram (
    .clk(clk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
    .raddr(comp_raddr), .rdata(comp_rdata)
  );

  itt_free_scan #(.BUFFER_COUNT(BUFFER_COUNT)) u_free_scan (
    .clk(clk), .rst(rst), .ctl(scan_ctl), .free_map(freev),
    .done(scan_done), .first(scan_first)
  );

  assign s_tready = (state == S_IDLE);

  // arm checks
  logic          arm_in_range;
  logic [IW-1:0] arm_idx;
  logic          arm_ok;
  logic [15:0]   gen_new;
  assign arm_in_range = (int'(in_buf) < BUFFER_COUNT);
  assign arm_idx      = IW'(in_buf);
  assign arm_ok       = arm_in_range && freev[arm_idx] && (pcount < CW'(BUFFER_COUNT));
  assign gen_new      = (genv[arm_idx] ? gen_rdata : 16'd0) + 16'd1;

  // queue tails: head plus count, wrapped once
  logic [CW:0]   ptail_sum, ctail_sum;
  logic [IW-1:0] ptail, ctail;
  assign ptail_sum = {1'b0, CW'(phead)} + {1'b0, pcount};
  assign ctail_sum = {1'b0, CW'(chead)} + {1'b0, ccount};
  assign ptail = (ptail_sum >= (CW+1)'(BUFFER_COUNT)) ?
                 IW'(ptail_sum - (CW+1)'(BUFFER_COUNT)) : IW'(ptail_sum);
  assign ctail = (ctail_sum >= (CW+1)'(BUFFER_COUNT)) ?
                 IW'(ctail_sum - (CW+1)'(BUFFER_COUNT)) : IW'(ctail_sum);

  // retire of the outstanding head
  logic          ret_last;
  logic [IW-1:0] ret_idx;
  logic [16:0]   ret_res;
  logic          comp_room;
  assign ret_last  = (ret_left == '0);
  assign ret_idx   = IW'(pend_rdata.buf_id);
  assign ret_res   = !ret_last ? 17'd0 :
                     ((in_res <= {7'd0, pend_rdata.len}) ? in_res[16:0] : pend_rdata.len);
  assign comp_room = (ccount < CW'(BUFFER_COUNT));

  // take
  logic [IW-1:0] take_idx;
  logic [15:0]   gen_cur;
  assign take_idx = IW'(t_buf);
  assign gen_cur  = genv[take_idx] ? gen_rdata : 16'd0;

  always_comb begin
    gen_we     = 1'b0;
    gen_waddr  = arm_idx;
    gen_wdata  = gen_new;
    gen_raddr  = arm_idx;
    pend_we    = 1'b0;
    pend_waddr = ptail;
    pend_wdata = '{gen: gen_new, len: in_len, buf_id: in_buf, addr: in_addr};
    pend_raddr = phead;
    comp_we    = 1'b0;
    comp_waddr = ctail;
    comp_wdata = '{code: ret_last ? in_code : itt_pkg::CODE_SUCCESS,
                   gen: pend_rdata.gen, res: ret_res, req: pend_rdata.len,
                   buf_id: pend_rdata.buf_id, addr: pend_rdata.addr};
    comp_raddr = chead;
    scan_ctl.start = (state == S_FREE_GO);
    case (state)
      S_ARM_WR:   begin
        gen_we  = 1'b1;
        pend_we = 1'b1;
      end
      S_SCAN_RD:  pend_raddr = scan_ptr;
      S_RET_WR:   comp_we = comp_room;
      S_TAKE_GEN: gen_raddr = IW'(comp_rdata.buf_id);
      S_TAKE_WR:  gen_raddr = take_idx;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phead      <= '0;
      chead      <= '0;
      pcount     <= '0;
      ccount     <= '0;
      freev      <= '1;
      compv      <= '0;
      genv       <= '0;
      lost_cnt   <= '0;
      skip_cnt   <= '0;
      gfault_cnt <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // the final state reloads the output register on its own
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_buf  <= s_tdata[3:0];
            in_addr <= s_tdata[67:4];
            in_len  <= s_tdata[84:68];
            in_code <= s_tdata[92:85];
            in_res  <= s_tdata[116:93];
            ok      <= 1'b0;
            t_addr  <= '0;
            t_buf   <= '0;
            t_req   <= '0;
            t_res   <= '0;
            t_gen   <= '0;
            t_code  <= '0;
            case (s_tuser)
              itt_pkg::ACT_ARM: state <= S_ARM_RD;
              itt_pkg::ACT_DELIVER: begin
                if (pcount == '0) begin
                  lost_cnt <= lost_cnt + 32'd1;
                  state    <= S_FREE_GO;
                end else begin
                  scan_k   <= '0;
                  scan_ptr <= phead;
                  state    <= S_SCAN_RD;
                end
              end
              itt_pkg::ACT_TAKE: state <= (ccount == '0) ? S_FREE_GO : S_TAKE_RD;
              default: state <= S_FREE_GO;
            endcase
          end
        end
        S_ARM_RD: state <= arm_ok ? S_ARM_WR : S_FREE_GO;
        S_ARM_WR: begin
          genv[arm_idx]  <= 1'b1;
          freev[arm_idx] <= 1'b0;
          pcount         <= pcount + 1'b1;
          ok             <= 1'b1;
          state          <= S_FREE_GO;
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (pend_rdata.addr == in_addr) begin
            ret_left <= scan_k;
            state    <= S_RET_RD;
          end else if (scan_k + 1'b1 == pcount) begin
            lost_cnt <= lost_cnt + 32'd1;
            state    <= S_FREE_GO;
          end else begin
            scan_k   <= scan_k + 1'b1;
            scan_ptr <= (scan_ptr == IW'(BUFFER_COUNT - 1)) ? '0 : scan_ptr + 1'b1;
            state    <= S_SCAN_RD;
          end
        end
        S_RET_RD: state <= S_RET_WR;
        S_RET_WR: begin
          if (comp_room) begin
            ccount         <= ccount + 1'b1;
            compv[ret_idx] <= 1'b1;
            freev[ret_idx] <= 1'b0;
          end else begin
            compv[ret_idx] <= 1'b0;
            freev[ret_idx] <= 1'b1;
          end
          phead  <= (phead == IW'(BUFFER_COUNT - 1)) ? '0 : phead + 1'b1;
          pcount <= pcount - 1'b1;
          if (ret_last) begin
            ok    <= 1'b1;
            state <= S_FREE_GO;
          end else begin
            skip_cnt <= skip_cnt + 32'd1;
            ret_left <= ret_left - 1'b1;
            state    <= S_RET_RD;
          end
        end
        S_TAKE_RD: state <= S_TAKE_GEN;
        S_TAKE_GEN: begin
          t_addr <= comp_rdata.addr;
          t_buf  <= comp_rdata.buf_id;
          t_req  <= comp_rdata.req;
          t_res  <= comp_rdata.res;
          t_gen  <= comp_rdata.gen;
          t_code <= comp_rdata.code;
          state  <= S_TAKE_WR;
        end
        S_TAKE_WR: begin
          if (gen_cur != t_gen) begin
            gfault_cnt <= gfault_cnt + 32'd1;
          end
          chead  <= (chead == IW'(BUFFER_COUNT - 1)) ? '0 : chead + 1'b1;
          ccount <= ccount - 1'b1;
          if (compv[take_idx]) begin
            compv[take_idx] <= 1'b0;
            freev[take_idx] <= 1'b1;
          end
          ok    <= 1'b1;
          state <= S_FREE_GO;
        end
        S_FREE_GO: state <= S_FREE_WT;
        S_FREE_WT: begin
          if (scan_done) begin
            ff    <= scan_first;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // load the output register once the previous result has gone
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'd0, gfault_cnt, skip_cnt, lost_cnt, 5'(ff), t_code, t_gen,
                         t_req - t_res, t_res, t_req, t_buf, t_addr, ok};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/interrupt_in_transfer_tracker_unit_test.sv @@
// self-checking testbench for the interrupt transfer tracker
`timescale 1ns / 1ps

module interrupt_in_transfer_tracker_unit_test;

  localparam int NBUF = 16;
  localparam logic [1:0] STAT_FREE = 2'd0;
  localparam logic [1:0] STAT_INFLIGHT = 2'd1;
  localparam logic [1:0] STAT_COMPLETED = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0]  fill;
    logic [23:0] residue;
    logic [7:0]  code;
    logic [16:0] req_len;
    logic [63:0] addr;
    logic [3:0]  buf_idx;
  } req_fields_t;

  typedef struct {
    logic [1:0]  action;
    req_fields_t f;
  } tracker_word_t;

  typedef struct packed {
    logic [2:0]  fill;
    logic [31:0] fault_total;
    logic [31:0] skipped;
    logic [31:0] lost;
    logic [4:0]  first_free;
    logic [7:0]  code;
    logic [15:0] gen;
    logic [16:0] actual;
    logic [16:0] residue;
    logic [16:0] requested;
    logic [3:0]  buf_id;
    logic [63:0] addr;
    logic        accepted;
  } tracker_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [119:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [247:0] m_tdata;

  interrupt_in_transfer_tracker_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // tracker shadow state
  logic [1:0]  buf_state [NBUF];
  logic [15:0] buf_gen [NBUF];
  itt_pkg::pend_word_t outstanding [$];
  itt_pkg::comp_word_t completions [$];
  logic [31:0] lost_cnt, skip_cnt, fault_cnt;

  tracker_word_t   word_queue [$];
  tracker_result_t expected_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  // the word on the input was taken at the last rising edge
  logic in_taken = 1'b0;
  longint cycles = 0;

  // addresses armed recently, used to aim deliveries at real entries
  logic [63:0] armed_addrs [$];

  function automatic void retire_oldest(logic [7:0] code, logic [23:0] residue);
    itt_pkg::pend_word_t p;
    itt_pkg::comp_word_t c;
    p = outstanding.pop_front();
    c.addr = p.addr;
    c.buf_id = p.buf_id;
    c.req = p.len;
    c.res = (residue <= {7'd0, p.len}) ? residue[16:0] : p.len;
    c.gen = p.gen;
    c.code = code;
    c.req = p.len;
    if (completions.size() < NBUF) begin
      completions.push_back(c);
      buf_state[p.buf_id] = STAT_COMPLETED;
    end else begin
      buf_state[p.buf_id] = STAT_FREE;
    end
  endfunction

  function automatic tracker_result_t predict_tracker(tracker_word_t w);
    tracker_result_t r;
    itt_pkg::pend_word_t p;
    itt_pkg::comp_word_t c;
    int hit;
    r = '0;
    case (w.action)
      itt_pkg::ACT_ARM: begin
        if (buf_state[w.f.buf_idx] == STAT_FREE && outstanding.size() < NBUF) begin
          buf_gen[w.f.buf_idx] = buf_gen[w.f.buf_idx] + 16'd1;
          buf_state[w.f.buf_idx] = STAT_INFLIGHT;
          p.addr = w.f.addr;
          p.buf_id = w.f.buf_idx;
          p.len = w.f.req_len;
          p.gen = buf_gen[w.f.buf_idx];
          outstanding.push_back(p);
          r.accepted = 1'b1;
        end
      end
      itt_pkg::ACT_DELIVER: begin
        hit = -1;
        foreach (outstanding[k])
          if (hit < 0 && outstanding[k].addr == w.f.addr) hit = k;
        if (hit < 0) begin
          lost_cnt++;
        end else begin
          repeat (hit) begin
            retire_oldest(itt_pkg::CODE_SUCCESS, 24'd0);
            skip_cnt++;
          end
          retire_oldest(w.f.code, w.f.residue);
          r.accepted = 1'b1;
        end
      end
      itt_pkg::ACT_TAKE: begin
        if (completions.size() > 0) begin
          c = completions.pop_front();
          if (buf_gen[c.buf_id] != c.gen) fault_cnt++;
          if (buf_state[c.buf_id] == STAT_COMPLETED) buf_state[c.buf_id] = STAT_FREE;
          r.accepted = 1'b1;
          r.addr = c.addr;
          r.buf_id = c.buf_id;
          r.requested = c.req;
          r.residue = c.res;
          r.actual = c.req - c.res;
          r.gen = c.gen;
          r.code = c.code;
        end
      end
      default: ;
    endcase
    r.first_free = 5'(NBUF);
    for (int b = NBUF - 1; b >= 0; b--)
      if (buf_state[b] == STAT_FREE) r.first_free = 5'(b);
    r.lost = lost_cnt;
    r.skipped = skip_cnt;
    r.fault_total = fault_cnt;
    return r;
  endfunction

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic tracker_word_t make_word(logic [1:0] act, logic [3:0] b,
                                              logic [63:0] a, logic [16:0] len,
                                              logic [7:0] code, logic [23:0] res);
    tracker_word_t w;
    w.action = act;
    w.f = '0;
    w.f.buf_idx = b;
    w.f.addr = a;
    w.f.req_len = len;
    w.f.code = code;
    w.f.residue = res;
    return w;
  endfunction

  // random word: arms, deliveries mostly aimed at armed addresses, takes and a rare unused action
  function automatic tracker_word_t random_word();
    int sel;
    logic [63:0] a;
    sel = $urandom_range(0, 99);
    a = rand_addr();
    if (sel < 38) begin
      // small address set makes duplicate addresses likely now and then
      if ($urandom_range(0, 9) == 0) a = 64'($urandom_range(0, 3));
      armed_addrs.push_back(a);
      if (armed_addrs.size() > 24) void'(armed_addrs.pop_front());
      return make_word(itt_pkg::ACT_ARM, 4'($urandom), a, 17'($urandom),
                       8'($urandom), 24'($urandom));
    end else if (sel < 70) begin
      if (armed_addrs.size() > 0 && $urandom_range(0, 9) < 8)
        a = armed_addrs[$urandom_range(0, armed_addrs.size() - 1)];
      return make_word(itt_pkg::ACT_DELIVER, 4'($urandom), a, 17'($urandom), 8'($urandom),
                       ($urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 70000))));
    end else if (sel < 97) begin
      return make_word(itt_pkg::ACT_TAKE, 4'($urandom), a, 17'($urandom), 8'($urandom),
                       24'($urandom));
    end
    return make_word(ACT_UNUSED, 4'($urandom), a, 17'($urandom), 8'($urandom),
                     24'($urandom));
  endfunction

  // driver: presents the next pending word at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // hold the word until it is taken
      end else if (word_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= word_queue[0].action;
        s_tdata <= word_queue[0].f;
        expected_results.push_back(predict_tracker(word_queue[0]));
        void'(word_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: notes taken words and checks each result word
  always @(posedge clk) begin
    tracker_result_t got, want;
    cycles <= cycles + 1;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted || got.addr !== want.addr ||
            got.buf_id !== want.buf_id || got.requested !== want.requested ||
            got.residue !== want.residue || got.actual !== want.actual ||
            got.gen !== want.gen || got.code !== want.code ||
            got.first_free !== want.first_free || got.lost !== want.lost ||
            got.skipped !== want.skipped || got.fault_total !== want.fault_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, got);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic run_phase(int n);
    repeat (n) word_queue.push_back(random_word());
    wait (word_queue.size() == 0);
  endtask

  initial begin
    for (int b = 0; b < NBUF; b++) begin
      buf_state[b] = STAT_FREE;
      buf_gen[b] = '0;
    end
    lost_cnt = '0;
    skip_cnt = '0;
    fault_cnt = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: take on empty, unused action, delivery with nothing outstanding, arms with extreme fields
    word_queue.push_back(make_word(itt_pkg::ACT_TAKE, 4'd0, '0, '0, '0, '0));
    word_queue.push_back(make_word(ACT_UNUSED, 4'hF, '1, '1, '1, '1));
    word_queue.push_back(make_word(itt_pkg::ACT_DELIVER, 4'd0, 64'h1234, '0, '0, '0));
    word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'd0, '0, '0, '0, '0));
    word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'd0, 64'h5, 17'd5, '0, '0));
    word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'hF, '1, '1, '1, '1));
    word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'd7, 64'hAAAA_5555_AAAA_5555,
                                   17'd100, '0, '0));
    word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'd3, 64'h5555_AAAA_5555_AAAA,
                                   17'h0AAAA, '0, '0));
    // deliver third entry: two older ones retire as skipped, residue oversized
    word_queue.push_back(make_word(itt_pkg::ACT_DELIVER, 4'd0, 64'hAAAA_5555_AAAA_5555, '0,
                                   8'hFF, 24'hFFFFFF));
    word_queue.push_back(make_word(itt_pkg::ACT_DELIVER, 4'hF, 64'h5555_AAAA_5555_AAAA, '1,
                                   8'h00, 24'h000010));
    for (int i = 0; i < 5; i++)
      word_queue.push_back(make_word(itt_pkg::ACT_TAKE, 4'd0, '0, '0, '0, '0));
    // fill the whole pool, overfill, then drain
    for (int b = 0; b < NBUF; b++)
      word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'(b), 64'(b + 100), 17'(b), '0, '0));
    word_queue.push_back(make_word(itt_pkg::ACT_ARM, 4'd2, 64'd999, 17'd1, '0, '0));
    word_queue.push_back(make_word(itt_pkg::ACT_DELIVER, 4'd0, 64'd115, '0, 8'h2A, 24'd3));
    for (int i = 0; i < NBUF; i++)
      word_queue.push_back(make_word(itt_pkg::ACT_TAKE, 4'd0, '0, '0, '0, '0));
    wait (word_queue.size() == 0);

    send_idle_pct = 28;
    recv_idle_pct = 68;
    run_phase(400);
    send_idle_pct = 68;
    recv_idle_pct = 28;
    run_phase(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(400);

    @(negedge clk);
    wait (!s_tvalid || s_tready);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ interrupt_in_transfer_tracker_unit.f @@
src/itt_pkg.sv
src/itt_ram.sv
src/itt_free_scan.sv
src/interrupt_in_transfer_tracker_unit.sv
tb/interrupt_in_transfer_tracker_unit_test.sv
